@@ rtl/lpfd_pkg.sv @@
// Shared types and constants for the length-prefixed frame decoder.
package lpfd_pkg;

  localparam logic [7:0]  ERR_OP         = 8'h7F;
  localparam logic [7:0]  WIDE_REQ_A     = 8'h09;
  localparam logic [7:0]  WIDE_REQ_B     = 8'h11;
  localparam logic [7:0]  RESP_BIT_CLEAR = 8'hEF;
  localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;

  localparam logic [2:0] ST_OK_RESP    = 3'd0;
  localparam logic [2:0] ST_OK_ERR     = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd2;
  localparam logic [2:0] ST_TRUNC_LEN  = 3'd3;
  localparam logic [2:0] ST_SIZE_MISM  = 3'd4;
  localparam logic [2:0] ST_CSUM_MISM  = 3'd5;
  localparam logic [2:0] ST_BAD_ERRLEN = 3'd6;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [2:0]  status;
    logic [7:0]  frame_opcode;
    logic [15:0] payload_length;
    logic [7:0]  failed_request_opcode;
    logic [7:0]  device_error_code;
  } result_t;

endpackage

@@ rtl/lpfd_front.sv @@
// Front end: accepts frame bytes, tracks the frame and builds result items.
module lpfd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  input  logic            q_full,
  output logic            push,
  output lpfd_pkg::result_t push_data
);
  import lpfd_pkg::*;

  localparam logic [2:0] PH_OPCODE = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_TAIL   = 3'd4;

  logic [2:0]  phase;
  logic [16:0] byte_count;
  logic [7:0]  running_sum;
  logic [7:0]  held_opcode;
  logic        err_frame;
  logic        wide_len;
  logic [15:0] decl_len;
  logic [7:0]  err_req;
  logic [7:0]  err_code;

  logic        accept;
  logic [1:0]  lsize;
  logic [16:0] hdr_len;
  logic [15:0] idx;
  logic [2:0]  st;
  logic [15:0] lenrep;
  logic        wide_op;
  logic        data_end;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    lsize    = (wide_len && byte_count != 17'd0) ? 2'd2 : 2'd1;
    hdr_len  = {15'd0, lsize} + 17'd1;
    idx      = byte_count[15:0] - hdr_len[15:0];
    data_end = ({1'b0, idx} + 17'd1) >= {1'b0, decl_len};
    wide_op  = ((data_byte & RESP_BIT_CLEAR) == WIDE_REQ_A) ||
               ((data_byte & RESP_BIT_CLEAR) == WIDE_REQ_B);
    lenrep   = 16'd0;
    if (byte_count < 17'd2) begin
      st = ST_TOO_SHORT;
    end else if (byte_count < hdr_len) begin
      st = ST_TRUNC_LEN;
    end else begin
      lenrep = (phase == PH_LEN_LO) ? (decl_len | {8'd0, data_byte}) : decl_len;
      if ({1'b0, byte_count} != ({1'b0, hdr_len} + {2'd0, decl_len})) begin
        st = ST_SIZE_MISM;
      end else if (~running_sum != data_byte) begin
        st = ST_CSUM_MISM;
      end else if (err_frame && decl_len != 16'd2) begin
        st = ST_BAD_ERRLEN;
      end else begin
        st = err_frame ? ST_OK_ERR : ST_OK_RESP;
      end
    end

    push_data = '0;
    if (last_byte) begin
      push = accept;
      push_data.kind           = KIND_STATUS;
      push_data.status         = st;
      push_data.frame_opcode   = (byte_count == 17'd0) ? data_byte : held_opcode;
      push_data.payload_length = lenrep;
      if (st == ST_OK_ERR) begin
        push_data.failed_request_opcode = err_req;
        push_data.device_error_code     = err_code;
      end
    end else begin
      push = accept && phase == PH_DATA && !err_frame;
      push_data.kind           = KIND_PAYLOAD;
      push_data.payload_byte   = data_byte;
      push_data.payload_index  = idx;
      push_data.frame_opcode   = held_opcode;
      push_data.payload_length = decl_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase       <= PH_OPCODE;
      byte_count  <= '0;
      running_sum <= '0;
      held_opcode <= '0;
      err_frame   <= 1'b0;
      wide_len    <= 1'b0;
      decl_len    <= '0;
      err_req     <= '0;
      err_code    <= '0;
    end else if (accept) begin
      case (phase)
        PH_OPCODE: begin
          held_opcode <= data_byte;
          err_frame   <= (data_byte == ERR_OP);
          wide_len    <= (data_byte != ERR_OP) && wide_op;
          decl_len    <= '0;
          phase       <= PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (wide_len) begin
            decl_len <= {data_byte, 8'd0};
            phase    <= PH_LEN_LO;
          end else begin
            decl_len <= {8'd0, data_byte};
            phase    <= (data_byte != 8'd0) ? PH_DATA : PH_TAIL;
          end
        end
        PH_LEN_LO: begin
          decl_len <= decl_len | {8'd0, data_byte};
          phase    <= ((decl_len | {8'd0, data_byte}) != 16'd0) ? PH_DATA : PH_TAIL;
        end
        PH_DATA: begin
          // hold the first two payload bytes of an error frame
          if (err_frame) begin
            if (idx == 16'd0) begin
              err_req <= data_byte;
            end else if (idx == 16'd1) begin
              err_code <= data_byte;
            end
          end
          if (data_end) begin
            phase <= PH_TAIL;
          end
        end
        default: begin
          phase <= PH_TAIL;
        end
      endcase
      running_sum <= running_sum + data_byte;
      if (byte_count < COUNT_MAX) begin
        byte_count <= byte_count + 17'd1;
      end
    end
  end

endmodule

@@ rtl/lpfd_fifo.sv @@
// Short result queue between the front end and the output stage.
module lpfd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpfd_pkg::result_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output lpfd_pkg::result_t pop_data
);
  import lpfd_pkg::*;

  result_t        mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == (QAW+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/lpfd_back.sv @@
// Output stage: holds one result item toward the consumer.
module lpfd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  lpfd_pkg::result_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output lpfd_pkg::result_t out_data
);
  import lpfd_pkg::*;

  // load a new item whenever the output slot is empty or being taken
  assign q_pop = q_not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= q_data;
    end
  end

endmodule

@@ rtl/length_prefixed_frame_decoder.sv @@
// Length-prefixed frame decoder top level.
// Path: a result item is written into the result queue when its byte is taken, and is
// then loaded into the registered output slot, which holds it while out_stall is high.
// Throughput: one byte per cycle; the per-byte frame tracker and the queue both run
// at one item a cycle, and input stalls only when the four-entry result queue fills.
// Reset: synchronous rst returns the frame tracker to awaiting an opcode and empties
// the queue and output slot.
module length_prefixed_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [2:0]  status,
  output logic [7:0]  frame_opcode,
  output logic [15:0] payload_length,
  output logic [7:0]  failed_request_opcode,
  output logic [7:0]  device_error_code
);
  import lpfd_pkg::*;

  logic    q_full;
  logic    push;
  result_t push_data;
  logic    q_not_empty;
  logic    q_pop;
  result_t q_data;
  result_t out_data;

  lpfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  lpfd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  lpfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  assign kind                  = out_data.kind;
  assign payload_byte          = out_data.payload_byte;
  assign payload_index         = out_data.payload_index;
  assign status                = out_data.status;
  assign frame_opcode          = out_data.frame_opcode;
  assign payload_length        = out_data.payload_length;
  assign failed_request_opcode = out_data.failed_request_opcode;
  assign device_error_code     = out_data.device_error_code;

endmodule
